// ===== hdl/dlio_pkg.sv =====
// ----------------------------------------------------------------------------
// dlio_pkg
// Shared types, constants and the 7-segment lookup for the display/lamp
// I/O latch.
// ----------------------------------------------------------------------------
package dlio_pkg;

  localparam int unsigned RegCount  = 32;
  localparam int unsigned AddrWidth = 5;

  // Bus access kinds
  localparam logic MODE_READ  = 1'b0;
  localparam logic MODE_WRITE = 1'b1;

  // Bank that forms the sound command, and the one holding its high nybble
  localparam logic [3:0]           BANK_SOUND    = 4'd2;
  localparam logic [AddrWidth-1:0] REG_SOUND_HI  = 5'd19;
  localparam logic [7:0]           SOUND_RESET   = 8'hff;

  // One result transaction
  typedef struct packed {
    logic [7:0] read_data;
    logic       digit_valid;
    logic [3:0] digit_pair;
    logic [6:0] segments_high;
    logic [6:0] segments_low;
    logic       bank_valid;
    logic [3:0] bank;
    logic       solenoid_valid;
    logic [3:0] solenoid_bits;
    logic [3:0] lamp_bits;
    logic [7:0] sound_command;
    logic       sound_trigger;
  } result_t;

  // Storage updates produced by one access
  typedef struct packed {
    logic       rf_we;
    logic       latch_we;
    logic [7:0] latch_data;
  } update_t;

  // Nybble to segment pattern; code 15 is blank
  function automatic logic [6:0] seg_lookup(input logic [3:0] nyb);
    logic [6:0] seg;
    case (nyb)
      4'h0:    seg = 7'h3f;
      4'h1:    seg = 7'h06;
      4'h2:    seg = 7'h5b;
      4'h3:    seg = 7'h4f;
      4'h4:    seg = 7'h66;
      4'h5:    seg = 7'h6d;
      4'h6:    seg = 7'h7c;
      4'h7:    seg = 7'h07;
      4'h8:    seg = 7'h7f;
      4'h9:    seg = 7'h67;
      4'ha:    seg = 7'h58;
      4'hb:    seg = 7'h4c;
      4'hc:    seg = 7'h62;
      4'hd:    seg = 7'h69;
      4'he:    seg = 7'h78;
      default: seg = 7'h00;
    endcase
    return seg;
  endfunction

endpackage

// ===== hdl/display_lamp_io_latch.sv =====
// ----------------------------------------------------------------------------
// display_lamp_io_latch
// Bus-side I/O register file driving digit, lamp, solenoid and sound outputs.
// ----------------------------------------------------------------------------
// One bus access per cycle. Each accepted transaction updates the register
// file and sound latch at the accepting edge and its result appears in the
// output register on the next cycle; a new transaction is taken every cycle
// unless the output register holds a result that is stalled. The work is a
// register-file read, a segment-table lookup and one byte compare, all in a
// single stage ahead of the output register. After reset the register file is
// zero and the sound latch is 0xff.
module display_lamp_io_latch (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_mode,
  input  logic [4:0] in_reg_offset,
  input  logic [7:0] in_write_data,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_read_data,
  output logic       out_digit_valid,
  output logic [3:0] out_digit_pair,
  output logic [6:0] out_segments_high,
  output logic [6:0] out_segments_low,
  output logic       out_bank_valid,
  output logic [3:0] out_bank,
  output logic       out_solenoid_valid,
  output logic [3:0] out_solenoid_bits,
  output logic [3:0] out_lamp_bits,
  output logic [7:0] out_sound_command,
  output logic       out_sound_trigger
);

  logic              accept;
  logic [7:0]        rf_rdata;
  logic [3:0]        sound_hi;
  logic [7:0]        latch_r;
  logic              out_valid_r;
  logic              out_valid_nxt;
  dlio_pkg::result_t res;
  dlio_pkg::result_t res_r;
  dlio_pkg::update_t upd;

  // Handshake: stall only while a result waits
  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  dlio_regfile u_regfile (
    .clk      (clk),
    .rst_n    (rst_n),
    .we       (accept && upd.rf_we),
    .addr     (in_reg_offset),
    .wdata    (in_write_data),
    .rdata    (rf_rdata),
    .sound_hi (sound_hi)
  );

  dlio_decode u_decode (
    .mode       (in_mode),
    .reg_offset (in_reg_offset),
    .write_data (in_write_data),
    .rf_rdata   (rf_rdata),
    .sound_hi   (sound_hi),
    .latch      (latch_r),
    .result     (res),
    .update     (upd)
  );

  // Sound command latch
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      latch_r <= dlio_pkg::SOUND_RESET;
    end else if (accept && upd.latch_we) begin
      latch_r <= upd.latch_data;
    end
  end

  // Output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_read_data      = res_r.read_data;
  assign out_digit_valid    = res_r.digit_valid;
  assign out_digit_pair     = res_r.digit_pair;
  assign out_segments_high  = res_r.segments_high;
  assign out_segments_low   = res_r.segments_low;
  assign out_bank_valid     = res_r.bank_valid;
  assign out_bank           = res_r.bank;
  assign out_solenoid_valid = res_r.solenoid_valid;
  assign out_solenoid_bits  = res_r.solenoid_bits;
  assign out_lamp_bits      = res_r.lamp_bits;
  assign out_sound_command  = res_r.sound_command;
  assign out_sound_trigger  = res_r.sound_trigger;

`ifndef ASSERT_OFF
  // Accepted transaction always shows up at the output next cycle
  a_accept_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid)
    else $error("accepted transaction did not reach the output register");

  // Sound trigger only on a bank 2 write
  a_trigger_bank: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_sound_trigger) |->
      (out_bank_valid && out_bank == dlio_pkg::BANK_SOUND))
    else $error("sound trigger outside a bank 2 write");

  // Trigger means the latch moved to the shown command
  a_trigger_latch: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && upd.latch_we) |=> (out_sound_trigger && latch_r == out_sound_command))
    else $error("sound latch and reported command disagree");

  // Digit and bank writes are exclusive and return no read data
  a_digit_excl: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_digit_valid) |-> (!out_bank_valid && out_read_data == 8'h00))
    else $error("digit write overlaps bank write or read data");
`endif

endmodule

// ===== hdl/dlio_regfile.sv =====
// ----------------------------------------------------------------------------
// dlio_regfile
// 32 x 8 register file: one write port, one addressed read port and a fixed
// tap on the high nybble of the sound-command register.
// ----------------------------------------------------------------------------
module dlio_regfile (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           we,
  input  logic [dlio_pkg::AddrWidth-1:0] addr,
  input  logic [7:0]                     wdata,
  output logic [7:0]                     rdata,
  output logic [3:0]                     sound_hi
);

  logic [7:0] rf_r [dlio_pkg::RegCount];

  // Storage, cleared on reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < dlio_pkg::RegCount; i++) begin
        rf_r[i] <= 8'h00;
      end
    end else if (we) begin
      rf_r[addr] <= wdata;
    end
  end

  // Read taps
  assign rdata    = rf_r[addr];
  assign sound_hi = rf_r[dlio_pkg::REG_SOUND_HI][7:4];

endmodule

// ===== hdl/dlio_decode.sv =====
// ----------------------------------------------------------------------------
// dlio_decode
// Combinational access decode: read data, digit segments, lamp/solenoid
// slices and the sound-command compare.
// ----------------------------------------------------------------------------
module dlio_decode (
  input  logic                           mode,
  input  logic [dlio_pkg::AddrWidth-1:0] reg_offset,
  input  logic [7:0]                     write_data,
  input  logic [7:0]                     rf_rdata,
  input  logic [3:0]                     sound_hi,
  input  logic [7:0]                     latch,
  output dlio_pkg::result_t              result,
  output dlio_pkg::update_t              update
);

  logic       is_write;
  logic       is_bank;
  logic [3:0] bank_idx;
  logic [7:0] cmd;
  logic       snd_change;

  assign is_write   = (mode == dlio_pkg::MODE_WRITE);
  assign is_bank    = reg_offset[4];
  assign bank_idx   = reg_offset[3:0];
  // Sound command: high nybble from register 19, low nybble from the high nybble of the byte being written now
  assign cmd        = {sound_hi, write_data[7:4]};
  assign snd_change = is_write && is_bank && (bank_idx == dlio_pkg::BANK_SOUND)
                      && (cmd != latch);

  // Storage updates
  always_comb begin
    update.rf_we      = is_write;
    update.latch_we   = snd_change;
    update.latch_data = cmd;
  end

  // Result fields
  always_comb begin
    result = '0;
    if (!is_write) begin
      result.read_data = rf_rdata;
    end else if (!is_bank) begin
      result.digit_valid   = 1'b1;
      result.digit_pair    = bank_idx;
      result.segments_high = dlio_pkg::seg_lookup(write_data[7:4]);
      result.segments_low  = dlio_pkg::seg_lookup(write_data[3:0]);
    end else begin
      result.bank_valid = 1'b1;
      result.bank       = bank_idx;
      result.lamp_bits  = write_data[3:0];
      if (bank_idx[3:1] == 3'd0) begin
        result.solenoid_valid = 1'b1;
        result.solenoid_bits  = write_data[7:4];
      end
    end
    result.sound_trigger = snd_change;
    result.sound_command = snd_change ? cmd : latch;
  end

endmodule
